### design/lockset_race_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lockset race detector.
// Each macro checks a property on the rising clock edge and is disabled
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef LOCKSET_RACE_DETECTOR_ASSERT_SVH
`define LOCKSET_RACE_DETECTOR_ASSERT_SVH

// Same-cycle implication: whenever the antecedent holds, so must the consequent.
`define LRD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lockset race detector: same-cycle check failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define LRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lockset race detector: next-cycle check failed");

`endif

### design/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types and constants for the lockset race detector: field widths,
// command and word-state codes, and the controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lrd_pkg;

  // Table sizes.
  localparam int NUM_LOCKS   = 16;
  localparam int NUM_THREADS = 8;
  localparam int NUM_WORDS   = 256;

  // Field widths of one event and one result.
  localparam int CMD_W    = 2;
  localparam int THREAD_W = 3;
  localparam int WORD_W   = 8;
  localparam int LOCK_W   = 4;
  localparam int STATE_W  = 2;
  localparam int CAND_W   = 16;

  // Lockset of a word that has never been touched: every lock is a candidate.
  localparam logic [NUM_LOCKS-1:0] LOCK_MASK = {NUM_LOCKS{1'b1}};

  // Event commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_ACQUIRE = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  // Shadow-word states.
  typedef enum logic [STATE_W-1:0] {
    MODE_VIRGIN = 2'd0,
    MODE_EXCL   = 2'd1,
    MODE_SHARED = 2'd2,
    MODE_SHMOD  = 2'd3
  } mode_t;

  // One shadow-word table entry.
  typedef struct packed {
    mode_t                 mode;
    logic [THREAD_W-1:0]   owner;
    logic [NUM_LOCKS-1:0]  lockset;
  } word_entry_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming word and start the table read
    logic commit;   // write back state and load the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

### design/lrd_ctrl.sv
// ----------------------------------------------------------------------------
// lrd_ctrl
// Controller for the lockset race detector. Takes one input word, waits for
// the registered table read, then commits the update once the result
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_ctrl
  import lrd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dp_cmd_t      dp_cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid || !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall       = 1'b0;
        dp_cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        dp_cmd.commit = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result valid flag: set on commit, cleared when the receiver takes the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### design/lrd_datapath.sv
// ----------------------------------------------------------------------------
// lrd_datapath
// Datapath of the lockset race detector: the shadow-word table with its
// valid bits, the per-thread held-lock registers, the Eraser state update
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrd_datapath
  import lrd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dp_cmd_t               dp_cmd,
  input  wire logic [CMD_W-1:0]      cmd,
  input  wire logic [THREAD_W-1:0]   thread_num,
  input  wire logic [WORD_W-1:0]     word_index,
  input  wire logic [LOCK_W-1:0]     lock_id,
  output logic                       race_warning,
  output logic [STATE_W-1:0]         word_state,
  output logic [CAND_W-1:0]          candidate_set,
  output logic [THREAD_W-1:0]        owner_thread
);

  // Shadow-word table and its valid bits; an invalid entry reads as reset.
  word_entry_t          word_mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] word_vld;
  word_entry_t          rd_entry;
  logic                 rd_vld;

  // Per-thread held locks.
  logic [NUM_LOCKS-1:0] held_locks [NUM_THREADS];

  // Captured event.
  cmd_t                 cmd_q;
  logic [THREAD_W-1:0]  tid_q;
  logic [WORD_W-1:0]    widx_q;
  logic [LOCK_W-1:0]    lid_q;

  // Update logic.
  logic                 is_lock;
  logic                 is_write;
  logic                 thread_ok;
  logic                 lock_ok;
  logic                 word_ok;
  logic [NUM_LOCKS-1:0] held_cur;
  logic [NUM_LOCKS-1:0] held_new;
  logic [NUM_LOCKS-1:0] lock_bit;
  word_entry_t          cur;
  word_entry_t          upd;
  logic                 race_next;
  logic [STATE_W-1:0]   state_next;
  logic [CAND_W-1:0]    cand_next;
  logic [THREAD_W-1:0]  owner_next;

  // Capture the event and read the table entry it names.
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q    <= cmd_t'(cmd);
      tid_q    <= thread_num;
      widx_q   <= word_index;
      lid_q    <= lock_id;
      rd_entry <= word_mem[word_index];
      rd_vld   <= word_vld[word_index];
    end
  end

  // Range checks and decode.
  assign is_lock   = (cmd_q == CMD_ACQUIRE) || (cmd_q == CMD_RELEASE);
  assign is_write  = (cmd_q == CMD_WRITE);
  assign thread_ok = ({1'b0, tid_q} < (THREAD_W + 1)'(NUM_THREADS));
  assign lock_ok   = ({1'b0, lid_q} < (LOCK_W + 1)'(NUM_LOCKS));
  assign word_ok   = ({1'b0, widx_q} < (WORD_W + 1)'(NUM_WORDS));
  assign held_cur  = thread_ok ? held_locks[tid_q] : '0;
  assign lock_bit  = NUM_LOCKS'(1) << lid_q;

  // New held set for lock commands.
  always_comb begin
    held_new = held_cur;
    if (thread_ok && lock_ok) begin
      if (cmd_q == CMD_ACQUIRE) begin
        held_new = held_cur | lock_bit;
      end else begin
        held_new = held_cur & ~lock_bit;
      end
    end
  end

  // Eraser state transition for an access.
  always_comb begin
    if (rd_vld) begin
      cur = rd_entry;
    end else begin
      cur.mode    = MODE_VIRGIN;
      cur.owner   = '0;
      cur.lockset = LOCK_MASK;
    end
    upd = cur;
    case (cur.mode)
      MODE_VIRGIN: begin
        upd.mode  = MODE_EXCL;
        upd.owner = tid_q;
      end
      MODE_EXCL: begin
        if (cur.owner != tid_q) begin
          upd.mode    = is_write ? MODE_SHMOD : MODE_SHARED;
          upd.lockset = cur.lockset & held_cur;
        end
      end
      default: begin
        upd.lockset = cur.lockset & held_cur;
        if (is_write) begin
          upd.mode = MODE_SHMOD;
        end
      end
    endcase
  end

  // Result word for the captured event.
  always_comb begin
    race_next  = 1'b0;
    state_next = MODE_VIRGIN;
    cand_next  = CAND_W'(LOCK_MASK);
    owner_next = '0;
    if (is_lock) begin
      cand_next = CAND_W'(held_new);
    end else if (word_ok) begin
      race_next  = (upd.mode == MODE_SHMOD) && (upd.lockset == '0);
      state_next = upd.mode;
      cand_next  = CAND_W'(upd.lockset);
      owner_next = (upd.mode == MODE_EXCL) ? upd.owner : '0;
    end
  end

  // Table write-back on commit of an in-range access.
  always_ff @(posedge clk) begin
    if (dp_cmd.commit && !is_lock && word_ok) begin
      word_mem[widx_q] <= upd;
    end
  end

  // Valid bits: reset marks every word untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_vld <= '0;
    end else if (dp_cmd.commit && !is_lock && word_ok) begin
      word_vld[widx_q] <= 1'b1;
    end
  end

  // Held-lock registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_THREADS; i++) begin
        held_locks[i] <= '0;
      end
    end else if (dp_cmd.commit && is_lock && thread_ok) begin
      held_locks[tid_q] <= held_new;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      race_warning  <= race_next;
      word_state    <= state_next;
      candidate_set <= cand_next;
      owner_thread  <= owner_next;
    end
  end

endmodule

`default_nettype wire

### design/lockset_race_detector.sv
// ----------------------------------------------------------------------------
// lockset_race_detector
// Lockset (Eraser) data-race detector over a stream of access and lock
// events.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one event word: cmd,
//   thread_num, word_index and lock_id. The output channel (out_valid /
//   out_stall) returns exactly one result word per event, in order:
//   race_warning, word_state, candidate_set and owner_thread.
//   Each event goes through a read of the shadow-word table, whose read
//   data is registered, and then an update of the entry with a load of
//   the result register. The block takes no new event until the previous
//   one has been committed.
//   A new event is taken while an earlier result still waits in the output
//   register; if the receiver stalls, the next update holds until that
//   result is taken, and in_stall stays high meanwhile.
//   Reset clears the held-lock registers and the table valid bits, so
//   every word reads Virgin with a full lockset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lockset_race_detector_assert.svh"

module lockset_race_detector
  import lrd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      cmd,
  input  wire logic [THREAD_W-1:0]   thread_num,
  input  wire logic [WORD_W-1:0]     word_index,
  input  wire logic [LOCK_W-1:0]     lock_id,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       race_warning,
  output logic [STATE_W-1:0]         word_state,
  output logic [CAND_W-1:0]          candidate_set,
  output logic [THREAD_W-1:0]        owner_thread
);

  dp_cmd_t dp_cmd;

  // Sequencing of capture and commit.
  lrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  // Tables, state update and result register.
  lrd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .cmd           (cmd),
    .thread_num    (thread_num),
    .word_index    (word_index),
    .lock_id       (lock_id),
    .race_warning  (race_warning),
    .word_state    (word_state),
    .candidate_set (candidate_set),
    .owner_thread  (owner_thread)
  );

  // A warning is only ever reported for a SharedModified word with no candidates.
  `LRD_ASSERT_NOW(a_warn_shmod, clk, rst, out_valid && race_warning, (word_state == MODE_SHMOD) && (candidate_set == '0))

  // An owner is only reported while the word is Exclusive.
  `LRD_ASSERT_NOW(a_owner_excl, clk, rst, out_valid && (owner_thread != '0), word_state == MODE_EXCL)

  // After taking an event the block is busy while its update is pending.
  `LRD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire
